// File: rtl/pre_pkg.sv
// ============================================================================
// pre_pkg: shared types and constants of the palette range editor
// Command and status codes, sequencer states and the divider interface.
// ============================================================================
package pre_pkg;

    localparam int IDX_W    = 10;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 24;
    localparam int MODE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int DEN_W    = 10;
    localparam int NUM_CH   = 3;

    localparam logic [MODE_W-1:0] MODE_GRADIENT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SET_ENDS = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INVERT   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_GREY     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SWAP_RB  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SWAP_RG  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_SWAP_GB  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ROTATE   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_READ     = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // floor(x / 3) for x below 1024 equals (x * 683) >> 11.
    localparam logic [9:0] GREY_RECIP = 10'd683;
    localparam int         GREY_SHIFT = 11;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PRIME,
        ST_RUN,
        ST_SET_FIRST,
        ST_SET_LAST,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CAP_LAST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] quo;
        logic [DEN_W-1:0]  rem;
    } t_div_rsp;

endpackage

// File: rtl/pre_div.sv
// ============================================================================
// pre_div: iterative restoring divider
// Divides an 8-bit magnitude by a 10-bit divisor, one quotient bit a cycle.
// ============================================================================
module pre_div
    import pre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int               CNT_W    = $clog2(CHAN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHAN_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [CHAN_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[CHAN_W-1]};
        fits  = trial >= {1'b0, r_den};
        n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[CHAN_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// File: rtl/palette_range_editor.sv
// ============================================================================
// palette_range_editor: RGB palette with range edit commands
// Applies gradient, set, invert, grey, swap and rotate edits over a range.
// ============================================================================
// The slave stream takes one command beat: a mode, an inclusive index range
// and two colours. The master stream returns one result beat per command:
// a status code and the colours found at both end indices afterwards.
// A command is taken only while the sequencer is idle; o_s_tready is low
// while a command is worked on. A range edit walks the palette memory one
// entry per cycle, reading entry i+1 while writing entry i. A gradient
// first runs three divisions on the shared divider to get per-channel
// step quotients and remainders; after that each entry is one add and
// compare per channel. After reset the palette is cleared by a pass over
// all PALETTE_ENTRIES entries, one entry a cycle, during which no command
// is taken. The result sits in an output register: a stalled receiver
// does not block the next command, but a finished result waits until the
// previous one has been taken.
// ============================================================================
module palette_range_editor
    import pre_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command beat.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: mode[3:0], first_index[13:4], last_index[23:14],
    // start_red[31:24], start_green[39:32], start_blue[47:40],
    // end_red[55:48], end_green[63:56], end_blue[71:64].
    input  logic [71:0] i_s_tdata,
    // Result beat.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: status[1:0], first_red[9:2], first_green[17:10],
    // first_blue[25:18], last_red[33:26], last_green[41:34],
    // last_blue[49:42], zero fill [55:50].
    output logic [55:0] o_m_tdata
);

    localparam int            AW       = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] IDX_LAST = AW'(PALETTE_ENTRIES - 1);
    localparam logic [16:0]   LIMIT    = 17'(PALETTE_ENTRIES);
    localparam logic [1:0]    CH_LAST  = 2'(NUM_CH - 1);

    // ------------------------------------------------------------------
    // Command fields as they arrive.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] in_mode;
    logic [IDX_W-1:0]  in_first;
    logic [IDX_W-1:0]  in_last;
    logic              in_oor;
    logic              in_rev;

    assign in_mode  = i_s_tdata[3:0];
    assign in_first = i_s_tdata[13:4];
    assign in_last  = i_s_tdata[23:14];
    assign in_oor   = ({7'b0, in_first} >= LIMIT) || ({7'b0, in_last} >= LIMIT);
    assign in_rev   = in_first > in_last;

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [AW-1:0]       r_idx;
    logic [1:0]          r_ch;
    logic [MODE_W-1:0]   r_mode;
    logic [IDX_W-1:0]    r_first;
    logic [IDX_W-1:0]    r_last;
    logic [DEN_W-1:0]    r_den;
    logic [CHAN_W-1:0]   r_s [NUM_CH];
    logic [CHAN_W-1:0]   r_e [NUM_CH];

    // Gradient stepping: q = floor(n * |d| / den), acc = remainder.
    logic [CHAN_W-1:0]   r_qd  [NUM_CH];
    logic [DEN_W-1:0]    r_rd  [NUM_CH];
    logic                r_neg [NUM_CH];
    logic [CHAN_W-1:0]   r_q   [NUM_CH];
    logic [DEN_W-1:0]    r_acc [NUM_CH];

    logic [STATUS_W-1:0] r_res_status;
    logic [COLOR_W-1:0]  r_res_first;
    logic [COLOR_W-1:0]  r_res_last;
    logic                r_out_valid;
    logic [55:0]         r_out_data;

    logic [COLOR_W-1:0]  r_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0]  r_rdata;

    logic [AW-1:0]       first_a;
    logic [AW-1:0]       last_a;

    assign first_a = AW'(r_first);
    assign last_a  = AW'(r_last);

    // ------------------------------------------------------------------
    // Shared divider for the gradient setup.
    // ------------------------------------------------------------------
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic [CHAN_W:0]   ch_diff;
    logic              ch_neg;
    logic [CHAN_W-1:0] ch_mag;

    always_comb begin
        ch_diff = {1'b0, r_e[r_ch]} - {1'b0, r_s[r_ch]};
        ch_neg  = ch_diff[CHAN_W];
        ch_mag  = ch_neg ? CHAN_W'(-ch_diff) : ch_diff[CHAN_W-1:0];
    end

    pre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Per-entry edit of the colour read from the palette.
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]  cur_r, cur_g, cur_b;
    logic [9:0]         grey_sum;
    logic [19:0]        grey_prod;
    logic [CHAN_W-1:0]  grey_avg;
    logic [CHAN_W-1:0]  grad [NUM_CH];
    logic [COLOR_W-1:0] new_col;

    always_comb begin
        cur_r     = r_rdata[23:16];
        cur_g     = r_rdata[15:8];
        cur_b     = r_rdata[7:0];
        grey_sum  = {2'b0, cur_r} + {2'b0, cur_g} + {2'b0, cur_b};
        grey_prod = {10'b0, grey_sum} * {10'b0, GREY_RECIP};
        grey_avg  = CHAN_W'(grey_prod >> GREY_SHIFT);
        for (int k = 0; k < NUM_CH; k++) begin
            grad[k] = r_neg[k] ? (r_s[k] - r_q[k]) : (r_s[k] + r_q[k]);
        end
        unique case (r_mode)
            MODE_GRADIENT: new_col = {grad[0], grad[1], grad[2]};
            MODE_INVERT:   new_col = ~r_rdata;
            MODE_GREY:     new_col = {grey_avg, grey_avg, grey_avg};
            MODE_SWAP_RB:  new_col = {cur_b, cur_g, cur_r};
            MODE_SWAP_RG:  new_col = {cur_g, cur_r, cur_b};
            MODE_SWAP_GB:  new_col = {cur_r, cur_b, cur_g};
            default:       new_col = {cur_g, cur_b, cur_r};
        endcase
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == IDX_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    priority if (in_oor) begin
                        n_state = ST_FINISH;
                    end else if (in_rev) begin
                        n_state = ST_RD_FIRST;
                    end else if (in_mode == MODE_SET_ENDS) begin
                        n_state = ST_SET_FIRST;
                    end else if (in_mode == MODE_GRADIENT && in_first == in_last) begin
                        n_state = ST_SET_FIRST;
                    end else if (in_mode == MODE_GRADIENT) begin
                        n_state = ST_DIV_GO;
                    end else if (in_mode < MODE_READ) begin
                        n_state = ST_PRIME;
                    end else begin
                        n_state = ST_RD_FIRST;
                    end
                end
            end
            ST_DIV_GO:    n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) n_state = (r_ch == CH_LAST) ? ST_PRIME : ST_DIV_GO;
            end
            ST_PRIME:     n_state = ST_RUN;
            ST_RUN: begin
                if (r_idx == last_a) n_state = ST_RD_FIRST;
            end
            ST_SET_FIRST: n_state = (r_mode == MODE_SET_ENDS) ? ST_SET_LAST : ST_RD_FIRST;
            ST_SET_LAST:  n_state = ST_RD_FIRST;
            ST_RD_FIRST:  n_state = ST_RD_LAST;
            ST_RD_LAST:   n_state = ST_CAP_LAST;
            ST_CAP_LAST:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: memory ports, divider start, ready.
    // ------------------------------------------------------------------
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [COLOR_W-1:0] mem_wd;
    logic [AW-1:0]      mem_ra;
    logic               out_load;

    always_comb begin
        mem_we           = 1'b0;
        mem_wa           = r_idx;
        mem_wd           = '0;
        mem_ra           = r_idx;
        o_s_tready       = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ch_mag;
        div_req.divisor  = r_den;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_DIV_GO: begin
                div_req.start = 1'b1;
            end
            ST_RUN: begin
                mem_we = 1'b1;
                mem_wd = new_col;
                mem_ra = r_idx + 1'b1;
            end
            ST_SET_FIRST: begin
                mem_we = 1'b1;
                mem_wa = first_a;
                mem_wd = {r_s[0], r_s[1], r_s[2]};
            end
            ST_SET_LAST: begin
                mem_we = 1'b1;
                mem_wa = last_a;
                mem_wd = {r_e[0], r_e[1], r_e[2]};
            end
            ST_RD_FIRST: begin
                mem_ra = first_a;
            end
            ST_RD_LAST: begin
                mem_ra = last_a;
            end
            ST_FINISH: begin
                out_load = !r_out_valid || i_m_tready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Palette memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_RUN) begin
                r_idx <= r_idx + 1'b1;
            end else if (r_state == ST_IDLE && i_s_tvalid) begin
                r_idx <= AW'(in_first);
                r_ch  <= '0;
            end
            if (r_state == ST_DIV_WAIT && div_rsp.done) r_ch <= r_ch + 1'b1;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    logic [DEN_W:0] step_sum [NUM_CH];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            step_sum[k] = {1'b0, r_acc[k]} + {1'b0, r_rd[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_mode       <= in_mode;
            r_first      <= in_first;
            r_last       <= in_last;
            r_den        <= in_last - in_first;
            r_s[0]       <= i_s_tdata[31:24];
            r_s[1]       <= i_s_tdata[39:32];
            r_s[2]       <= i_s_tdata[47:40];
            r_e[0]       <= i_s_tdata[55:48];
            r_e[1]       <= i_s_tdata[63:56];
            r_e[2]       <= i_s_tdata[71:64];
            r_res_first  <= '0;
            r_res_last   <= '0;
            r_res_status <= in_oor ? STATUS_RANGE : (in_rev ? STATUS_EMPTY : STATUS_DONE);
            for (int k = 0; k < NUM_CH; k++) begin
                r_q[k]   <= '0;
                r_acc[k] <= '0;
            end
        end
        if (r_state == ST_DIV_WAIT && div_rsp.done) begin
            r_qd[r_ch]  <= div_rsp.quo;
            r_rd[r_ch]  <= div_rsp.rem;
            r_neg[r_ch] <= ch_neg;
        end
        // Advance the quotient by |d| / den for the next entry.
        if (r_state == ST_RUN && r_mode == MODE_GRADIENT) begin
            for (int k = 0; k < NUM_CH; k++) begin
                if (step_sum[k] >= {1'b0, r_den}) begin
                    r_acc[k] <= DEN_W'(step_sum[k] - {1'b0, r_den});
                    r_q[k]   <= r_q[k] + r_qd[k] + 1'b1;
                end else begin
                    r_acc[k] <= step_sum[k][DEN_W-1:0];
                    r_q[k]   <= r_q[k] + r_qd[k];
                end
            end
        end
        if (r_state == ST_RD_LAST)  r_res_first <= r_rdata;
        if (r_state == ST_CAP_LAST) r_res_last  <= r_rdata;
        // The palette keeps red on top; the beat puts red lowest.
        if (out_load) begin
            r_out_data <= {6'b0,
                           r_res_last[7:0], r_res_last[15:8], r_res_last[23:16],
                           r_res_first[7:0], r_res_first[15:8], r_res_first[23:16],
                           r_res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // The palette is never written while a command could be accepted.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("palette written while idle");

    // The range walk never passes the last index of the command.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_idx <= last_a))
        else $error("range walk beyond last index");

    // The divider only reports while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV_WAIT))
        else $error("divider result outside setup");

    // A rejected out-of-range command reports zero colours.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == STATUS_RANGE) |-> (o_m_tdata[49:2] == '0))
        else $error("out-of-range result carries colours");
`endif

endmodule

// File: tb/sv/palette_range_editor_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// palette_range_editor_tb: self-checking bench for the palette range editor
// Drives command beats, mirrors the palette in a bench-side model and checks
// every result beat field by field under several idle and stall patterns.
// ============================================================================
module palette_range_editor_tb
    import pre_pkg::*;
();

    localparam int PALETTE_ENTRIES  = 1024;
    localparam int MODE_LAST_CODE   = (1 << MODE_W) - 1;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int DRAIN_CYCLES     = 32;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  first_idx;
        logic [IDX_W-1:0]  last_idx;
        t_rgb              from_rgb;
        t_rgb              to_rgb;
    } t_edit_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_rgb                at_first;
        t_rgb                at_last;
    } t_edit_result;

    // One line of the directed table. Rows with a typed expectation carry
    // it in want; the others take the expectation from the palette mirror.
    typedef struct {
        t_edit_cmd    cmd;
        bit           typed;
        t_edit_result want;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // Fields from bit 0 up: mode, first_index, last_index, start_red,
    // start_green, start_blue, end_red, end_green, end_blue.
    logic [71:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // Fields from bit 0 up: status, first_red, first_green, first_blue,
    // last_red, last_green, last_blue, zero fill.
    logic [55:0] o_m_tdata;

    // Bench-side copy of the palette, updated as each command is accepted.
    t_rgb            palette_model [PALETTE_ENTRIES];
    t_edit_result    expected_results [$];
    t_directed_row   directed_rows [$];
    t_edit_result    oldest_want;

    int unsigned tx_gap_pct   = 0;
    int unsigned rx_stall_pct = 0;
    int          n_fail       = 0;
    int          n_checked    = 0;
    int          n_sent       = 0;
    int          n_reversed   = 0;
    int          n_long_walks = 0;
    int          mode_count [16];

    always #5 i_clk = ~i_clk;

    palette_range_editor #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    // ------------------------------------------------------------------------
    // Palette mirror
    // ------------------------------------------------------------------------

    // One channel of a gradient entry: start plus the scaled difference, with
    // the quotient truncated toward zero and the sum wrapped to eight bits.
    function automatic logic [CHAN_W-1:0] ramp_channel(logic [CHAN_W-1:0] s,
                                                       logic [CHAN_W-1:0] e,
                                                       int num, int den);
        int diff;
        diff = int'(e) - int'(s);
        return CHAN_W'(int'(s) + (num * diff) / den);
    endfunction

    // Applies one command to the mirror and returns the result beat that the
    // block has to produce for it.
    function automatic t_edit_result apply_edit(t_edit_cmd c);
        t_edit_result res;
        t_rgb         px;
        int           avg;
        int           den;
        res = '0;
        if (int'(c.first_idx) >= PALETTE_ENTRIES || int'(c.last_idx) >= PALETTE_ENTRIES) begin
            res.status = STATUS_RANGE;
            return res;
        end
        den = int'(c.last_idx) - int'(c.first_idx);
        if (c.first_idx > c.last_idx) begin
            // A reversed range leaves the palette alone for every mode.
            res.status = STATUS_EMPTY;
        end else if (c.mode == MODE_SET_ENDS) begin
            // On a single entry the end colour is written second and wins.
            palette_model[c.first_idx] = c.from_rgb;
            palette_model[c.last_idx]  = c.to_rgb;
        end else if (c.mode == MODE_GRADIENT && den == 0) begin
            palette_model[c.first_idx] = c.from_rgb;
        end else if (c.mode <= MODE_ROTATE) begin
            for (int i = c.first_idx; i <= c.last_idx; i++) begin
                px = palette_model[i];
                case (c.mode)
                    MODE_GRADIENT: begin
                        px.r = ramp_channel(c.from_rgb.r, c.to_rgb.r, i - c.first_idx, den);
                        px.g = ramp_channel(c.from_rgb.g, c.to_rgb.g, i - c.first_idx, den);
                        px.b = ramp_channel(c.from_rgb.b, c.to_rgb.b, i - c.first_idx, den);
                    end
                    MODE_INVERT: begin
                        px = ~px;
                    end
                    MODE_GREY: begin
                        avg = (int'(px.r) + int'(px.g) + int'(px.b)) / 3;
                        px  = {CHAN_W'(avg), CHAN_W'(avg), CHAN_W'(avg)};
                    end
                    MODE_SWAP_RB: begin
                        px = {px.b, px.g, px.r};
                    end
                    MODE_SWAP_RG: begin
                        px = {px.g, px.r, px.b};
                    end
                    MODE_SWAP_GB: begin
                        px = {px.r, px.b, px.g};
                    end
                    MODE_ROTATE: begin
                        // Red takes green, green takes blue, blue takes red.
                        px = {px.g, px.b, px.r};
                    end
                    default: begin
                    end
                endcase
                palette_model[i] = px;
            end
        end
        // Read and the unused codes fall through to here unchanged.
        res.at_first = palette_model[c.first_idx];
        res.at_last  = palette_model[c.last_idx];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------

    function automatic t_edit_cmd make_cmd(int mode, int first, int last,
                                           logic [23:0] from_c, logic [23:0] to_c);
        t_edit_cmd c;
        c.mode      = MODE_W'(mode);
        c.first_idx = IDX_W'(first);
        c.last_idx  = IDX_W'(last);
        c.from_rgb  = from_c;
        c.to_rgb    = to_c;
        return c;
    endfunction

    task automatic row_typed(int mode, int first, int last, logic [23:0] from_c,
                             logic [23:0] to_c, logic [STATUS_W-1:0] status,
                             logic [23:0] at_first, logic [23:0] at_last);
        t_directed_row row;
        row.cmd           = make_cmd(mode, first, last, from_c, to_c);
        row.typed         = 1'b1;
        row.want.status   = status;
        row.want.at_first = at_first;
        row.want.at_last  = at_last;
        directed_rows.push_back(row);
    endtask

    task automatic row_pred(int mode, int first, int last, logic [23:0] from_c,
                            logic [23:0] to_c);
        t_directed_row row;
        row.cmd   = make_cmd(mode, first, last, from_c, to_c);
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Random commands
    // ------------------------------------------------------------------------

    // Channels sit at zero or full scale now and then, else anywhere.
    function automatic logic [CHAN_W-1:0] random_channel();
        if ($urandom_range(9) == 0)
            return CHAN_W'($urandom_range(1) * 255);
        return CHAN_W'($urandom_range(255));
    endfunction

    // Most commands walk short ranges, many of them inside a small hot area
    // so that edits pile up on the same entries; a few walk long ranges.
    function automatic t_edit_cmd random_edit();
        t_edit_cmd   c;
        int unsigned pick;
        int unsigned span;
        int unsigned base;
        int unsigned far_end;
        pick = $urandom_range(99);
        if (pick < 22)
            c.mode = MODE_GRADIENT;
        else if (pick < 36)
            c.mode = MODE_SET_ENDS;
        else if (pick < 80)
            c.mode = MODE_W'($urandom_range(MODE_INVERT, MODE_ROTATE));
        else if (pick < 93)
            c.mode = MODE_READ;
        else
            c.mode = MODE_W'($urandom_range(MODE_READ + 1, MODE_LAST_CODE));
        pick = $urandom_range(99);
        if (pick < 2)
            span = $urandom_range(512, PALETTE_ENTRIES - 1);
        else if (pick < 12)
            span = $urandom_range(16, 127);
        else
            span = $urandom_range(15);
        base    = ($urandom_range(99) < 65) ? $urandom_range(63)
                                             : $urandom_range(PALETTE_ENTRIES - 1);
        far_end = (base + span > PALETTE_ENTRIES - 1) ? PALETTE_ENTRIES - 1 : base + span;
        if ($urandom_range(99) < 6) begin
            c.first_idx = IDX_W'(far_end);
            c.last_idx  = IDX_W'(base);
        end else begin
            c.first_idx = IDX_W'(base);
            c.last_idx  = IDX_W'(far_end);
        end
        c.from_rgb = {random_channel(), random_channel(), random_channel()};
        c.to_rgb   = {random_channel(), random_channel(), random_channel()};
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Presents one command beat, after a random gap, and holds it until the
    // block takes it. The expectation is queued at the accepting edge. The
    // valid stays high on return, so the next call either lowers it for a
    // gap or replaces the beat, one assignment per edge either way.
    task automatic send_edit(t_edit_cmd c, bit typed, t_edit_result want);
        t_edit_result predicted;
        while ($urandom_range(99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c.to_rgb.b, c.to_rgb.g, c.to_rgb.r,
                       c.from_rgb.b, c.from_rgb.g, c.from_rgb.r,
                       c.last_idx, c.first_idx, c.mode};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        // The mirror always advances; typed rows only replace the expectation.
        predicted = apply_edit(c);
        expected_results.push_back(typed ? want : predicted);
        n_sent++;
        mode_count[c.mode]++;
        if (c.first_idx > c.last_idx)
            n_reversed++;
        else if (c.last_idx - c.first_idx >= 512)
            n_long_walks++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the scoreboard
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // Outputs are sampled at the rising edge, before any update the block
    // makes at that edge, and tready is redrawn for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %h", o_m_tdata);
                    n_fail++;
                end else begin
                    oldest_want = expected_results.pop_front();
                    check_field("status",      oldest_want.status,     o_m_tdata[1:0]);
                    check_field("first_red",   oldest_want.at_first.r, o_m_tdata[9:2]);
                    check_field("first_green", oldest_want.at_first.g, o_m_tdata[17:10]);
                    check_field("first_blue",  oldest_want.at_first.b, o_m_tdata[25:18]);
                    check_field("last_red",    oldest_want.at_last.r,  o_m_tdata[33:26]);
                    check_field("last_green",  oldest_want.at_last.g,  o_m_tdata[41:34]);
                    check_field("last_blue",   oldest_want.at_last.b,  o_m_tdata[49:42]);
                    check_field("zero_fill",   0,                      o_m_tdata[55:50]);
                    n_checked++;
                end
            end
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        foreach (mode_count[m])
            mode_count[m] = 0;
        foreach (palette_model[k])
            palette_model[k] = '0;

        // Directed table. Typed rows hold results that follow straight from
        // the command: a cleared palette, a reversed range, the end entries
        // of a set or a gradient. The rest go through the mirror.
        row_typed(MODE_READ,     0,    1023, 24'h000000, 24'h000000,
                  STATUS_DONE,  24'h000000, 24'h000000);
        row_typed(MODE_GRADIENT, 7,    3,    24'hFFFFFF, 24'hFFFFFF,
                  STATUS_EMPTY, 24'h000000, 24'h000000);
        row_typed(MODE_SET_ENDS, 0,    1023, 24'hFF00FF, 24'h00FF00,
                  STATUS_DONE,  24'hFF00FF, 24'h00FF00);
        // Reversed set: nothing is written, both entries are reported.
        row_typed(MODE_SET_ENDS, 1023, 0,    24'h123456, 24'h654321,
                  STATUS_EMPTY, 24'h00FF00, 24'hFF00FF);
        // Set on a single entry: the end colour wins.
        row_typed(MODE_SET_ENDS, 10,   10,   24'h123456, 24'hABCDEF,
                  STATUS_DONE,  24'hABCDEF, 24'hABCDEF);
        // Gradient on a single entry writes the start colour.
        row_typed(MODE_GRADIENT, 20,   20,   24'h0F1E2D, 24'hFFFFFF,
                  STATUS_DONE,  24'h0F1E2D, 24'h0F1E2D);
        row_pred (MODE_READ,     9,    11,   24'h000000, 24'h000000);
        // Full-palette ramp, the longest walk the block can do.
        row_typed(MODE_GRADIENT, 0,    1023, 24'h000000, 24'hFFFFFF,
                  STATUS_DONE,  24'h000000, 24'hFFFFFF);
        row_pred (MODE_READ,     511,  512,  24'h000000, 24'h000000);
        // Falling, flat and rising channels in one ramp.
        row_typed(MODE_GRADIENT, 100,  355,  24'hFF8000, 24'h0080FF,
                  STATUS_DONE,  24'hFF8000, 24'h0080FF);
        row_typed(MODE_GRADIENT, 30,   36,   24'h000000, 24'h0A05FF,
                  STATUS_DONE,  24'h000000, 24'h0A05FF);
        row_pred (MODE_READ,     33,   34,   24'h000000, 24'h000000);
        // Negative steps: the quotient truncates toward zero.
        row_typed(MODE_GRADIENT, 40,   43,   24'h0A0A0A, 24'h000005,
                  STATUS_DONE,  24'h0A0A0A, 24'h000005);
        row_pred (MODE_READ,     41,   42,   24'h000000, 24'h000000);
        row_pred (MODE_INVERT,   30,   43,   24'h000000, 24'h000000);
        row_pred (MODE_GREY,     30,   36,   24'h000000, 24'h000000);
        row_pred (MODE_SWAP_RB,  100,  110,  24'h000000, 24'h000000);
        row_pred (MODE_SWAP_RG,  100,  110,  24'h000000, 24'h000000);
        row_pred (MODE_SWAP_GB,  100,  110,  24'h000000, 24'h000000);
        row_pred (MODE_ROTATE,   100,  103,  24'h000000, 24'h000000);
        row_pred (MODE_ROTATE,   1023, 1023, 24'h000000, 24'h000000);
        row_pred (MODE_INVERT,   0,    1023, 24'hFFFFFF, 24'hFFFFFF);
        row_pred (MODE_GREY,     5,    5,    24'h000000, 24'h000000);
        // Unused codes behave as read.
        row_pred (MODE_READ + 1, 0,    1023, 24'hFFFFFF, 24'hFFFFFF);
        row_pred (MODE_LAST_CODE, 30,  31,   24'hFFFFFF, 24'h000000);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first beat waits out the clearing pass through tready.
        foreach (directed_rows[r])
            send_edit(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

        // Random commands under four idle patterns: none, sender gaps,
        // receiver stalls, and both at once.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_gap_pct = 52; rx_stall_pct = 0;  end
                2:       begin tx_gap_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_gap_pct = 24; rx_stall_pct = 24; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_edit(random_edit(), 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        // Every command yields exactly one beat, so a short tail after the
        // last one is enough to catch a stray extra beat.
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands (%0d from the table), %0d result beats checked,",
                 n_sent, directed_rows.size(), n_checked);
        $display({"  %0d gradients, %0d set-ends, %0d reads, %0d unused codes,",
                  " %0d reversed, %0d long walks."},
                 mode_count[MODE_GRADIENT], mode_count[MODE_SET_ENDS], mode_count[MODE_READ],
                 n_sent - mode_count[MODE_GRADIENT] - mode_count[MODE_SET_ENDS]
                 - mode_count[MODE_READ] - mode_count[MODE_INVERT] - mode_count[MODE_GREY]
                 - mode_count[MODE_SWAP_RB] - mode_count[MODE_SWAP_RG]
                 - mode_count[MODE_SWAP_GB] - mode_count[MODE_ROTATE],
                 n_reversed, n_long_walks);
        if (n_fail == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, where every command
    // walks the whole palette behind long gaps and stalls.
    initial begin
        #40_000_000;
        $error("watchdog expired with %0d results outstanding", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
